// ===== hdl/buc_pkg.sv =====
// ============================================================================
// buc_pkg
// Shared constants for the binary and UTF-8 classifier: scan window size,
// counter widths and the byte codes the classifier looks for.
// ============================================================================
`default_nettype none

package buc_pkg;

    // Number of leading bytes that feed the null, control and printable counts.
    localparam int unsigned SCAN_LIMIT = 4096;

    // Counts never exceed SCAN_LIMIT, so this width always holds them.
    localparam int unsigned TALLY_W = $clog2(SCAN_LIMIT + 1);

    // Width of the scaled counts used in the control ratio compare.
    localparam int unsigned PROD_W = TALLY_W + 4;

    // Byte total width and its saturation value.
    localparam int unsigned TOTAL_W = 32;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Character codes.
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_DEL   = 8'h7F;

    // UTF-8 lead and continuation masks and patterns.
    localparam logic [7:0] U8_MASK2   = 8'hC0;
    localparam logic [7:0] U8_CONT    = 8'h80;
    localparam logic [7:0] U8_MASK3   = 8'hE0;
    localparam logic [7:0] U8_LEAD2   = 8'hC0;
    localparam logic [7:0] U8_MASK4   = 8'hF0;
    localparam logic [7:0] U8_LEAD3   = 8'hE0;
    localparam logic [7:0] U8_MASK5   = 8'hF8;
    localparam logic [7:0] U8_LEAD4   = 8'hF0;
    localparam logic [7:0] U8_MIN2    = 8'hC2;
    localparam logic [7:0] U8_MAX4    = 8'hF4;

    // Number of continuation bytes a lead byte asks for.
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_ONE   = 2'd1;
    localparam logic [1:0] PEND_TWO   = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    // Null count saturates here.
    localparam logic [1:0] NULL_SAT = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/binary_and_utf8_classifier.sv =====
// Result: a buffer's result is loaded into the result register as its last word
// leaves the input register. Throughput: one word per cycle unless a final word
// stalls while a result still waits; stalled words hold the input register.
// Reset: synchronous active-low i_rst_n clears the input and result valid flags
// and all counters, so the next accepted word starts a new buffer.
// ============================================================================
// binary_and_utf8_classifier
// Classifies a byte stream buffer as binary or text and checks it as UTF-8.
// One result word is produced per buffer, on the word that carries last_byte.
// ============================================================================
`default_nettype none

module binary_and_utf8_classifier (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input channel.
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [7:0]                     i_byte_value,
    input  wire logic                           i_last_byte,
    // Result channel.
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_binary_flag,
    output logic                                o_utf8_valid,
    output logic [buc_pkg::TOTAL_W-1:0]         o_byte_total
);

    // Input register.
    logic                                r_in_valid;
    logic [7:0]                          r_in_byte;
    logic                                r_in_last;

    // Buffer state.
    logic [1:0]                          r_null_seen,  n_null_seen;
    logic [buc_pkg::TALLY_W-1:0]         r_ctrl_cnt,   n_ctrl_cnt;
    logic [buc_pkg::TALLY_W-1:0]         r_print_cnt,  n_print_cnt;
    logic [buc_pkg::TOTAL_W-1:0]         r_position,   n_position;
    logic [1:0]                          r_pending,    n_pending;
    logic                                r_u8_err,     n_u8_err;

    // Result register.
    logic                                r_out_valid;
    logic                                r_binary_flag, n_binary_flag;
    logic                                r_utf8_valid, n_utf8_valid;
    logic [buc_pkg::TOTAL_W-1:0]         r_byte_total;

    logic                                out_free;
    logic                                s1_go;
    logic                                in_window;
    logic                                is_ctrl;
    logic                                is_print;
    logic [buc_pkg::PROD_W-1:0]          ctrl_scaled;
    logic [buc_pkg::PROD_W-1:0]          print_scaled;

    // Handshake: a final word moves on only when the result register is free.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !s1_go;

    // Byte classes.
    assign in_window = (r_position < 32'(buc_pkg::SCAN_LIMIT));
    assign is_ctrl   = (r_in_byte != buc_pkg::CHR_NUL) && (r_in_byte < buc_pkg::CHR_SPACE)
                       && (r_in_byte != buc_pkg::CHR_CR) && (r_in_byte != buc_pkg::CHR_LF)
                       && (r_in_byte != buc_pkg::CHR_TAB);
    assign is_print  = (r_in_byte >= buc_pkg::CHR_SPACE) && (r_in_byte < buc_pkg::CHR_DEL);

    // Counter and UTF-8 checker update for the word in the input register.
    always_comb begin
        n_null_seen = r_null_seen;
        n_ctrl_cnt  = r_ctrl_cnt;
        n_print_cnt = r_print_cnt;
        n_pending   = r_pending;
        n_u8_err    = r_u8_err;

        if (in_window) begin
            if (r_in_byte == buc_pkg::CHR_NUL) begin
                if (r_null_seen < buc_pkg::NULL_SAT) begin
                    n_null_seen = r_null_seen + 2'd1;
                end
            end else if (is_ctrl) begin
                n_ctrl_cnt = r_ctrl_cnt + buc_pkg::TALLY_W'(1);
            end else if (is_print) begin
                n_print_cnt = r_print_cnt + buc_pkg::TALLY_W'(1);
            end
        end

        if (!r_u8_err) begin
            if (r_pending != buc_pkg::PEND_NONE) begin
                if ((r_in_byte & buc_pkg::U8_MASK2) != buc_pkg::U8_CONT) begin
                    n_u8_err = 1'b1;
                end else begin
                    n_pending = r_pending - 2'd1;
                end
            end else if (r_in_byte[7]) begin
                if ((r_in_byte & buc_pkg::U8_MASK3) == buc_pkg::U8_LEAD2) begin
                    if (r_in_byte < buc_pkg::U8_MIN2) begin
                        n_u8_err = 1'b1;
                    end else begin
                        n_pending = buc_pkg::PEND_ONE;
                    end
                end else if ((r_in_byte & buc_pkg::U8_MASK4) == buc_pkg::U8_LEAD3) begin
                    n_pending = buc_pkg::PEND_TWO;
                end else if ((r_in_byte & buc_pkg::U8_MASK5) == buc_pkg::U8_LEAD4) begin
                    if (r_in_byte > buc_pkg::U8_MAX4) begin
                        n_u8_err = 1'b1;
                    end else begin
                        n_pending = buc_pkg::PEND_THREE;
                    end
                end else begin
                    n_u8_err = 1'b1;
                end
            end
        end

        n_position = (r_position != buc_pkg::TOTAL_MAX) ? r_position + buc_pkg::TOTAL_W'(1)
                                                        : r_position;
    end

    // Final judgement: binary on two nulls, or on 10 * control > 3 * printable (printable nonzero).
    assign ctrl_scaled  = (buc_pkg::PROD_W'(n_ctrl_cnt) << 3)
                        + (buc_pkg::PROD_W'(n_ctrl_cnt) << 1);
    assign print_scaled = (buc_pkg::PROD_W'(n_print_cnt) << 1)
                        + buc_pkg::PROD_W'(n_print_cnt);

    always_comb begin
        n_binary_flag = (n_null_seen >= buc_pkg::NULL_SAT)
                      || ((n_print_cnt != '0) && (ctrl_scaled > print_scaled));
        n_utf8_valid  = !n_binary_flag && !n_u8_err && (n_pending == buc_pkg::PEND_NONE);
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
    end

    // Buffer state: updated per word, cleared after the final word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null_seen <= '0;
            r_ctrl_cnt  <= '0;
            r_print_cnt <= '0;
            r_position  <= '0;
            r_pending   <= buc_pkg::PEND_NONE;
            r_u8_err    <= 1'b0;
        end else if (s1_go) begin
            if (r_in_last) begin
                r_null_seen <= '0;
                r_ctrl_cnt  <= '0;
                r_print_cnt <= '0;
                r_position  <= '0;
                r_pending   <= buc_pkg::PEND_NONE;
                r_u8_err    <= 1'b0;
            end else begin
                r_null_seen <= n_null_seen;
                r_ctrl_cnt  <= n_ctrl_cnt;
                r_print_cnt <= n_print_cnt;
                r_position  <= n_position;
                r_pending   <= n_pending;
                r_u8_err    <= n_u8_err;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_go && r_in_last;
        end
        if (s1_go && r_in_last) begin
            r_binary_flag <= n_binary_flag;
            r_utf8_valid  <= n_utf8_valid;
            r_byte_total  <= n_position;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_binary_flag = r_binary_flag;
    assign o_utf8_valid  = r_utf8_valid;
    assign o_byte_total  = r_byte_total;

endmodule

`default_nettype wire
